FILE: design/assert_macros.svh
// Assertion helpers used by the frame parser design.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_PROP(label, !(cond), msg)

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: design/lcfp_pkg.sv
`default_nettype none

package lcfp_pkg;

    localparam int FRAME_BYTES = 12;

    // Default reply codes for rejected frames.
    localparam logic [7:0] FRAME_ERROR_CODE_DEF = 8'd1;
    localparam logic [7:0] UNKNOWN_CODE_DEF     = 8'd2;

    // Reset value of every byte of the last accepted frame.
    localparam logic [7:0] LAST_FRAME_INIT = 8'h30;

    // Bytes sent in reply to a valid frame.
    localparam logic [1:0] REPLY_OK_BYTES = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FRAME_ERR = 2'd1,
        STAT_UNKNOWN   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_HEADER       = 3'd0,
        CFG_TAIL         = 3'd1,
        CFG_READ_CODE    = 3'd2,
        CFG_WRITE_CODE   = 3'd3,
        CFG_COMMAND_LOW  = 3'd4,
        CFG_COMMAND_HIGH = 3'd5,
        CFG_CLEAR_LIMIT  = 3'd6,
        CFG_OK_CODE      = 3'd7
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: design/led_command_frame_parser.sv
`default_nettype none
// Latency: the first reply byte is valid the cycle after the twelfth frame byte is taken.
// Throughput: one received byte per cycle; replies one byte per cycle unless stalled.
// The final byte of a frame stalls only while the previous frame's reply is still
// queued; without reply_stall, 12-byte frames and 1..3 reply bytes never limit the rate.
// Reset (rst_n low, asynchronous): byte count, reply queue and LED properties clear,
// last frame reads 0x30 per byte, configuration returns to its defaults.

module led_command_frame_parser #(
    parameter logic [7:0] FRAME_ERROR_CODE = lcfp_pkg::FRAME_ERROR_CODE_DEF,
    parameter logic [7:0] UNKNOWN_CODE     = lcfp_pkg::UNKNOWN_CODE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    // Received byte channel
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  active_command,

    // Reply channel
    output logic             reply_valid,
    input  wire logic        reply_stall,
    output logic [7:0]       reply_byte,
    output logic             reply_last,
    output logic [1:0]       frame_status,
    output logic             new_command,
    output logic             clear_request,
    output logic [7:0]       led_command,
    output logic [7:0]       first_led,
    output logic [7:0]       end_led,
    output logic [23:0]      led_color,
    output logic [15:0]      step_time,
    output logic [7:0]       led_direction
);

    import lcfp_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] header_reg;
    logic [7:0] tail_reg;
    logic [7:0] read_code_reg;
    logic [7:0] write_code_reg;
    logic [7:0] cmd_low_reg;
    logic [7:0] cmd_high_reg;
    logic [7:0] clear_limit_reg;
    logic [7:0] ok_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg      <= 8'd0;
            tail_reg        <= 8'd0;
            read_code_reg   <= 8'd0;
            write_code_reg  <= 8'd1;
            cmd_low_reg     <= 8'd0;
            cmd_high_reg    <= 8'd255;
            clear_limit_reg <= 8'd0;
            ok_code_reg     <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEADER:       header_reg      <= cfg_data;
                CFG_TAIL:         tail_reg        <= cfg_data;
                CFG_READ_CODE:    read_code_reg   <= cfg_data;
                CFG_WRITE_CODE:   write_code_reg  <= cfg_data;
                CFG_COMMAND_LOW:  cmd_low_reg     <= cfg_data;
                CFG_COMMAND_HIGH: cmd_high_reg    <= cfg_data;
                CFG_CLEAR_LIMIT:  clear_limit_reg <= cfg_data;
                CFG_OK_CODE:      ok_code_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic [1:0]       rep_left_reg;   // reply bytes still to send
    logic             rx_acc;
    logic             reply_acc;
    logic             frame_done;
    logic             rep_busy;
    logic [CNT_W-1:0] byte_count_reg;

    assign reply_valid = (rep_left_reg != 2'd0);
    assign reply_acc   = reply_valid && !reply_stall;

    // Reply queue still holds bytes after this edge.
    assign rep_busy = reply_valid && !(rep_left_reg == 2'd1 && reply_acc);

    // Only a frame-completing byte needs room in the reply queue.
    assign rx_stall   = (byte_count_reg == LAST_IDX) && rep_busy;
    assign rx_acc     = rx_valid && !rx_stall;
    assign frame_done = rx_acc && (byte_count_reg == LAST_IDX);

    // ------------------------------------------------------------------
    // Frame assembly: bytes land in place, no resync
    // ------------------------------------------------------------------
    logic [7:0] frame_store_reg [FRAME_BYTES];
    logic [7:0] last_frame_reg  [FRAME_BYTES];
    logic [7:0] frame_cur       [FRAME_BYTES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else if (rx_acc)
        begin
            byte_count_reg <= frame_done ? '0 : byte_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_acc)
        begin
            frame_store_reg[byte_count_reg] <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Frame checks, evaluated with the closing byte taken straight from rx
    // ------------------------------------------------------------------
    logic    hdr_ok;
    logic    is_write;
    logic    is_read;
    logic    cmd_ok;
    logic    differs;
    logic    store_new;
    logic    latch_props;
    logic    clr_now;
    status_t status_now;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_cur[i] = frame_store_reg[i];
        end
        frame_cur[FRAME_BYTES-1] = rx_byte;

        hdr_ok   = (frame_cur[0] == header_reg) && (frame_cur[FRAME_BYTES-1] == tail_reg);
        is_write = (frame_cur[1] == write_code_reg);
        is_read  = (frame_cur[1] == read_code_reg);
        // Empty range when low exceeds high falls out of the two compares.
        cmd_ok   = (is_write || is_read)
                   && (frame_cur[2] >= cmd_low_reg) && (frame_cur[2] <= cmd_high_reg);

        differs = 1'b0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            differs = differs || (frame_cur[i] != last_frame_reg[i]);
        end

        if (!hdr_ok)
        begin
            status_now = STAT_FRAME_ERR;
        end
        else if (!cmd_ok)
        begin
            status_now = STAT_UNKNOWN;
        end
        else
        begin
            status_now = STAT_OK;
        end

        store_new   = frame_done && (status_now == STAT_OK) && differs;
        latch_props = store_new && is_write;
        clr_now     = is_write && (frame_cur[2] <= clear_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                last_frame_reg[i] <= LAST_FRAME_INIT;
            end
        end
        else if (store_new)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                last_frame_reg[i] <= frame_cur[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Latched LED properties. They only move when a frame completes, and
    // the previous reply has fully drained by then, so each reply shows
    // the properties as they stand after its own frame.
    // ------------------------------------------------------------------
    logic [7:0]  prop_command_reg;
    logic [7:0]  prop_first_reg;
    logic [7:0]  prop_end_reg;
    logic [23:0] prop_color_reg;
    logic [15:0] prop_time_reg;
    logic [7:0]  prop_direction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_command_reg   <= 8'd0;
            prop_first_reg     <= 8'd0;
            prop_end_reg       <= 8'd0;
            prop_color_reg     <= 24'd0;
            prop_time_reg      <= 16'd0;
            prop_direction_reg <= 8'd0;
        end
        else if (latch_props)
        begin
            prop_command_reg   <= frame_cur[2];
            prop_first_reg     <= frame_cur[3];
            prop_end_reg       <= frame_cur[4];
            prop_color_reg     <= {frame_cur[5], frame_cur[6], frame_cur[7]};
            prop_time_reg      <= {frame_cur[8], frame_cur[9]};
            prop_direction_reg <= frame_cur[10];
        end
    end

    // ------------------------------------------------------------------
    // Reply queue: one transaction per byte, 1 byte on error, 3 on success
    // ------------------------------------------------------------------
    logic [1:0] rep_left_next;
    status_t    rep_status_reg;
    logic [7:0] rep_first_reg;    // error code or ok code
    logic [7:0] rep_cur_reg;      // echoed running command
    logic       rep_newc_reg;
    logic       rep_clr_reg;

    always_comb
    begin
        rep_left_next = rep_left_reg;
        if (frame_done)
        begin
            rep_left_next = (status_now == STAT_OK) ? REPLY_OK_BYTES : 2'd1;
        end
        else if (reply_acc)
        begin
            rep_left_next = rep_left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_left_reg   <= 2'd0;
            rep_status_reg <= STAT_OK;
            rep_newc_reg   <= 1'b0;
            rep_clr_reg    <= 1'b0;
        end
        else
        begin
            rep_left_reg <= rep_left_next;
            if (frame_done)
            begin
                rep_status_reg <= status_now;
                rep_newc_reg   <= store_new;
                rep_clr_reg    <= latch_props && clr_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            rep_cur_reg <= active_command;
            case (status_now)
                STAT_FRAME_ERR: rep_first_reg <= FRAME_ERROR_CODE;
                STAT_UNKNOWN:   rep_first_reg <= UNKNOWN_CODE;
                default:        rep_first_reg <= ok_code_reg;
            endcase
        end
    end

    always_comb
    begin
        if (rep_status_reg != STAT_OK)
        begin
            reply_byte = rep_first_reg;
        end
        else
        begin
            case (rep_left_reg)
                2'd3:    reply_byte = rep_first_reg;
                2'd2:    reply_byte = rep_cur_reg;
                default: reply_byte = tail_reg;
            endcase
        end
    end

    assign reply_last    = (rep_left_reg == 2'd1);
    assign frame_status  = rep_status_reg;
    assign new_command   = rep_newc_reg;
    assign clear_request = rep_clr_reg;
    assign led_command   = prop_command_reg;
    assign first_led     = prop_first_reg;
    assign end_led       = prop_end_reg;
    assign led_color     = prop_color_reg;
    assign step_time     = prop_time_reg;
    assign led_direction = prop_direction_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_reply_after_frame, frame_done |=> reply_valid, "no reply after frame end")
    `ASSERT_NEVER(a_count_range, byte_count_reg > LAST_IDX, "byte count out of frame")
    `ASSERT_PROP(a_error_single,
        (reply_valid && rep_status_reg != STAT_OK) |-> reply_last,
        "error reply longer than one byte")
    `ASSERT_PROP(a_clear_needs_new,
        (reply_valid && clear_request) |-> (new_command && rep_status_reg == STAT_OK),
        "clear pulse without new valid frame")
    `ASSERT_PROP(a_props_hold,
        !frame_done |=> ($stable(prop_command_reg) && $stable(prop_color_reg)),
        "LED properties moved between frames")

endmodule

`default_nettype wire
